/* src/glob_pattern_matcher_defines.svh */
// assertion macros for the glob pattern matcher checker
// no dependencies; expects clk and rst_n in the including scope
`ifndef GLOB_PATTERN_MATCHER_DEFINES_SVH
`define GLOB_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, reset masked
`define GPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define GPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gpm_pkg.sv */
// shared types, constants and helpers of the glob pattern matcher
// no dependencies
`default_nettype none

package gpm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int PAT_AW      = $clog2(MAX_PATTERN);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SUBJ   = 2'd2,
    REQ_END    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OPEN_SET = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_t       req_type;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic matched;
    err_t pattern_error;
  } out_beat_t;

  // pass request from control to scan engine
  typedef struct packed {
    logic       start;
    logic       advance;
    logic       fresh;
    logic [7:0] ch;
  } scan_req_t;

  // pass completion back to control
  typedef struct packed {
    logic done;
    logic act_end;
    logic open_set;
  } scan_rsp_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cf);
    logic [7:0] r;
    r = b;
    if (cf && (b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
      r = b + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/glob_pattern_matcher.sv */
// Glob pattern matcher, top level.
// Input channel in_valid/in_ready/in_data carries requests: clear pattern,
// append pattern byte, subject byte, end of subject. Output channel
// out_valid/out_ready/out_data carries one beat per end-of-subject request
// with the match flag and the pattern error code. cfg_we/cfg_wdata set
// case folding; they must be written only while the block is idle, and the
// block itself does not enforce it. Clear and append leave the block idle.
// A subject byte or an end request runs one pass over the stored pattern,
// one pattern ram read per cycle, and holds off new requests until it ends.
// An end request then passes through the done state, which loads the
// result into the output register.
// Reset empties the pattern, clears overflow and case folding and starts a
// fresh subject; the pattern ram content is not cleared and no reset pass
// is needed. When the receiver stalls, the result waits in the output
// register; the block keeps taking requests, and a second end result
// waits in the done state until the register frees up.
// uses gpm_pkg, gpm_scan
`default_nettype none

module glob_pattern_matcher
  import gpm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata
);

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             fresh_r, fresh_nxt;
  logic             is_end_r, is_end_nxt;
  logic             case_fold_r;
  logic             res_hit_r, res_bad_r;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;
  logic             in_fire;
  logic             pat_we;
  err_t             err;
  scan_req_t        sreq;
  scan_rsp_t        srsp;

  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gpm_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (sreq),
    .pat_len   (len_r),
    .case_fold (case_fold_r),
    .pat_we    (pat_we),
    .pat_waddr (len_r[PAT_AW-1:0]),
    .pat_wdata (in_data.data_byte),
    .rsp       (srsp)
  );

  // error code of the pending result
  always_comb begin
    if (ovf_r) begin
      err = ERR_OVERFLOW;
    end else if (res_bad_r) begin
      err = ERR_OPEN_SET;
    end else begin
      err = ERR_NONE;
    end
  end

  // request handling and sequencing
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    fresh_nxt     = fresh_r;
    is_end_nxt    = is_end_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    pat_we        = 1'b0;
    sreq.start    = 1'b0;
    sreq.advance  = 1'b0;
    sreq.fresh    = fresh_r;
    sreq.ch       = in_data.data_byte;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          unique case (in_data.req_type)
            REQ_CLEAR: begin
              len_nxt   = '0;
              ovf_nxt   = 1'b0;
              fresh_nxt = 1'b1;
            end
            REQ_APPEND: begin
              fresh_nxt = 1'b1;
              if (len_r < LEN_W'(MAX_PATTERN)) begin
                pat_we  = 1'b1;
                len_nxt = len_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            REQ_SUBJ: begin
              sreq.start   = 1'b1;
              sreq.advance = 1'b1;
              fresh_nxt    = 1'b0;
              is_end_nxt   = 1'b0;
              state_nxt    = ST_SCAN;
            end
            REQ_END: begin
              sreq.start = 1'b1;
              fresh_nxt  = 1'b1;
              is_end_nxt = 1'b1;
              state_nxt  = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (srsp.done) begin
          state_nxt = is_end_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.pattern_error  = err;
          out_data_nxt.matched        = (err == ERR_NONE) && res_hit_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      fresh_r     <= 1'b1;
      is_end_r    <= 1'b0;
      case_fold_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      fresh_r     <= fresh_nxt;
      is_end_r    <= is_end_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case_fold_r <= cfg_wdata;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (srsp.done) begin
      res_hit_r <= srsp.act_end;
      res_bad_r <= srsp.open_set;
    end
  end

endmodule

`default_nettype wire

/* src/gpm_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module gpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* src/gpm_scan.sv */
// scan engine: walks the stored pattern once per pass, parses tokens and
// updates the active position ram in place; uses gpm_pkg and gpm_ram
`default_nettype none

module gpm_scan
  import gpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scan_req_t         req,
  input  wire logic [LEN_W-1:0]  pat_len,
  input  wire logic              case_fold,
  input  wire logic              pat_we,
  input  wire logic [PAT_AW-1:0] pat_waddr,
  input  wire logic [7:0]        pat_wdata,
  output scan_rsp_t              rsp
);

  logic             iss_r, iss_nxt;
  logic [LEN_W-1:0] rq_r, rq_nxt;
  logic             vld_r;
  logic [LEN_W-1:0] pq_r;
  logic             adv_r, fresh_r;
  logic [7:0]       ch_r;

  // token parse state
  logic in_set_r, in_set_nxt;
  logic first_r, first_nxt;
  logic neg_r, neg_nxt;
  logic hit_r, hit_nxt;
  logic esc_r, esc_nxt;
  logic tok_a_r, tok_a_nxt;
  logic c_r, c_nxt;
  logic icarry_r, icarry_nxt;

  logic [7:0]       pat_rdata;
  logic             act_rdata;
  logic             act_we;
  logic             act_wdata;
  logic             tok_act;
  logic             eq;

  gpm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (rq_r[PAT_AW-1:0]),
    .rdata (pat_rdata)
  );

  gpm_ram #(.WIDTH(1), .DEPTH(MAX_PATTERN + 1)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (pq_r),
    .wdata (act_wdata),
    .raddr (rq_r),
    .rdata (act_rdata)
  );

  // read issue counter
  always_comb begin
    iss_nxt = iss_r;
    rq_nxt  = rq_r;
    if (req.start) begin
      iss_nxt = 1'b1;
      rq_nxt  = '0;
    end else if (iss_r) begin
      rq_nxt = rq_r + LEN_W'(1);
      if (rq_r == pat_len) begin
        iss_nxt = 1'b0;
      end
    end
  end

  // token parsing and in-place update
  always_comb begin
    in_set_nxt = in_set_r;
    first_nxt  = first_r;
    neg_nxt    = neg_r;
    hit_nxt    = hit_r;
    esc_nxt    = esc_r;
    tok_a_nxt  = tok_a_r;
    c_nxt      = c_r;
    icarry_nxt = icarry_r;
    act_we     = 1'b0;
    act_wdata  = c_r;
    tok_act    = fresh_r ? icarry_r : act_rdata;
    eq         = (fold_byte(pat_rdata, case_fold) == fold_byte(ch_r, case_fold));
    rsp.done     = 1'b0;
    rsp.act_end  = tok_act;
    rsp.open_set = in_set_r;

    if (req.start) begin
      in_set_nxt = 1'b0;
      first_nxt  = 1'b0;
      neg_nxt    = 1'b0;
      hit_nxt    = 1'b0;
      esc_nxt    = 1'b0;
      c_nxt      = 1'b0;
      icarry_nxt = 1'b1;
    end else if (vld_r) begin
      if (pq_r == pat_len) begin
        // end position: store final carry, report
        act_we   = adv_r;
        rsp.done = 1'b1;
      end else if (!in_set_r) begin
        // token start
        act_we = adv_r;
        if (pat_rdata == CH_STAR) begin
          act_wdata = c_r | tok_act;
          c_nxt     = c_r | tok_act;
        end else begin
          icarry_nxt = 1'b0;
          if (pat_rdata == CH_QMARK) begin
            c_nxt = tok_act;
          end else if (pat_rdata == CH_LBRACK) begin
            c_nxt      = 1'b0;
            in_set_nxt = 1'b1;
            first_nxt  = 1'b1;
            neg_nxt    = 1'b0;
            hit_nxt    = 1'b0;
            esc_nxt    = 1'b0;
            tok_a_nxt  = tok_act;
          end else begin
            c_nxt = tok_act & eq;
          end
        end
      end else begin
        // inside a set
        first_nxt = 1'b0;
        if (first_r && (pat_rdata == CH_TILDE)) begin
          neg_nxt = 1'b1;
        end else if (esc_r) begin
          esc_nxt = 1'b0;
          hit_nxt = hit_r | eq;
        end else if (pat_rdata == CH_RBRACK) begin
          in_set_nxt = 1'b0;
          c_nxt      = tok_a_r & (hit_r ^ neg_r);
        end else if (pat_rdata == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else begin
          hit_nxt = hit_r | eq;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      iss_r <= iss_nxt;
      vld_r <= iss_r;
    end
  end

  // pass context and parse registers
  always_ff @(posedge clk) begin
    rq_r     <= rq_nxt;
    pq_r     <= rq_r;
    in_set_r <= in_set_nxt;
    first_r  <= first_nxt;
    neg_r    <= neg_nxt;
    hit_r    <= hit_nxt;
    esc_r    <= esc_nxt;
    tok_a_r  <= tok_a_nxt;
    c_r      <= c_nxt;
    icarry_r <= icarry_nxt;
    if (req.start) begin
      adv_r   <= req.advance;
      fresh_r <= req.fresh;
      ch_r    <= req.ch;
    end
  end

endmodule

`default_nettype wire

/* src/gpm_checker.sv */
// port-level checker for the glob pattern matcher, bound to the top level
// uses gpm_pkg and glob_pattern_matcher_defines.svh
`default_nettype none
`include "glob_pattern_matcher_defines.svh"

module gpm_checker
  import gpm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_beat_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);

  // a stalled result beat stays
  `GPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

  // an error never comes with a match
  `GPM_ASSERT_NOW(a_err_nomatch, out_valid && (out_data.pattern_error != ERR_NONE),
                  !out_data.matched, "match reported with pattern error")

  // a non-end beat into an empty output produces no result
  `GPM_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && (in_data.req_type != REQ_END)
                   && !out_valid, !out_valid, "result without end request")

  // a pass keeps the input closed in the following cycle
  `GPM_ASSERT_NEXT(a_pass_busy, in_valid && in_ready && ((in_data.req_type == REQ_END)
                   || (in_data.req_type == REQ_SUBJ)), !in_ready, "input open during pass")

endmodule

bind glob_pattern_matcher gpm_checker u_gpm_checker (.*);

`default_nettype wire
